[rtl/core/hdx_pkg.sv]
// Shared types, codes and constants of the half-duplex transmit scheduler.
`default_nettype none

package hdx_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TAG_W           = 8;
    localparam int TIME_W          = 16;
    localparam int RETRY_W         = 4;
    localparam int EV_W            = 3;
    localparam int CMD_W           = 2;
    localparam int ADDR_W          = 4;
    localparam int DATA_W          = 32;
    localparam int MAX_RES         = 3;
    localparam int BQ_DEPTH        = 2;

    // Input item kinds.
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENQ   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FRAME = 2'd2;

    // Result event codes.
    localparam logic [EV_W-1:0] EV_NONE      = 3'd0;
    localparam logic [EV_W-1:0] EV_TRANSMIT  = 3'd1;
    localparam logic [EV_W-1:0] EV_ACK_OK    = 3'd2;
    localparam logic [EV_W-1:0] EV_ACK_FAIL  = 3'd3;
    localparam logic [EV_W-1:0] EV_PUBLISHED = 3'd4;
    localparam logic [EV_W-1:0] EV_DROPPED   = 3'd5;

    // Configuration register indexes (word address bits).
    localparam logic [1:0] REG_GAP     = 2'd0;
    localparam logic [1:0] REG_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_RETRY   = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0]  gap_ms;
        logic [TIME_W-1:0]  ack_timeout_ms;
        logic [RETRY_W-1:0] retry_limit;
    } cfg_t;

    typedef struct packed {
        logic [EV_W-1:0]  ev;
        logic [TAG_W-1:0] tag;
        logic             retry;
    } res_t;

    // All results of one input item; cnt holds 1 to MAX_RES.
    typedef struct packed {
        logic [1:0]              cnt;
        res_t [MAX_RES-1:0]      r;
    } bundle_t;

endpackage : hdx_pkg

`default_nettype wire

[rtl/core/hdx_fifo.sv]
// Tag FIFO with a registered head entry and a memory behind it.
`default_nettype none

module hdx_fifo #(
    parameter int DEPTH = hdx_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    input  wire logic                     pop,
    input  wire logic [hdx_pkg::TAG_W-1:0] din,
    output logic      [hdx_pkg::TAG_W-1:0] head,
    output logic                          empty,
    output logic                          full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [hdx_pkg::TAG_W-1:0] mem [DEPTH];
    logic [hdx_pkg::TAG_W-1:0] head_reg;
    logic [PW-1:0]             wr_ptr_reg;
    logic [PW-1:0]             rd_ptr_reg;
    logic [CW-1:0]             count_reg;
    logic                      do_push;
    logic                      do_pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CW'(DEPTH));
    assign head    = head_reg;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // The head register holds the oldest entry; the memory holds the rest.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else if (do_push)
        begin
            if (!empty)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            count_reg <= count_reg + CW'(1);
        end
        else if (do_pop)
        begin
            if (count_reg > CW'(1))
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            count_reg <= count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            if (empty)
            begin
                head_reg <= din;
            end
            else
            begin
                mem[wr_ptr_reg] <= din;
            end
        end
        else if (do_pop && (count_reg > CW'(1)))
        begin
            head_reg <= mem[rd_ptr_reg];
        end
    end

endmodule : hdx_fifo

`default_nettype wire

[rtl/core/hdx_front.sv]
// Front end: classifies each item, keeps scheduler state and builds its result bundle.
`default_nettype none

module hdx_front #(
    parameter int QUEUE_DEPTH = hdx_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      accept,
    input  wire logic [hdx_pkg::CMD_W-1:0] command,
    input  wire logic [hdx_pkg::TAG_W-1:0] cmd_tag,
    input  wire logic                      needs_ack,
    input  wire logic                      frame_ok,
    input  wire logic                      ack_match,
    input  wire hdx_pkg::cfg_t             cfg,
    output hdx_pkg::bundle_t               bundle
);

    logic                       pending_valid_reg, pending_valid_next;
    logic [hdx_pkg::TAG_W-1:0]   pending_tag_reg, pending_tag_next;
    logic                       awaiting_reg, awaiting_next;
    logic [hdx_pkg::RETRY_W-1:0] send_count_reg, send_count_next;
    logic [hdx_pkg::TIME_W-1:0]  since_rx_reg, since_rx_next;
    logic [hdx_pkg::TIME_W-1:0]  since_tx_reg, since_tx_next;

    logic                       ack_push, ack_pop, ack_empty, ack_full;
    logic                       late_push, late_pop, late_empty, late_full;
    logic [hdx_pkg::TAG_W-1:0]   ack_head, late_head;

    logic [hdx_pkg::TIME_W-1:0]  rx_inc, tx_inc;
    logic                       wait_on, blocked, give_up;
    logic [1:0]                 n_res;

    hdx_fifo #(.DEPTH(QUEUE_DEPTH)) u_ack_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (ack_push),
        .pop   (ack_pop),
        .din   (cmd_tag),
        .head  (ack_head),
        .empty (ack_empty),
        .full  (ack_full)
    );

    hdx_fifo #(.DEPTH(QUEUE_DEPTH)) u_late_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (late_push),
        .pop   (late_pop),
        .din   (cmd_tag),
        .head  (late_head),
        .empty (late_empty),
        .full  (late_full)
    );

    assign rx_inc  = (since_rx_reg != '1) ? since_rx_reg + 1'b1 : since_rx_reg;
    assign tx_inc  = (since_tx_reg != '1) ? since_tx_reg + 1'b1 : since_tx_reg;
    assign wait_on = awaiting_reg && !(tx_inc > cfg.ack_timeout_ms);
    assign blocked = (rx_inc < cfg.gap_ms) || (tx_inc < cfg.gap_ms) || wait_on;
    assign give_up = (cfg.retry_limit <= send_count_reg);

    always_comb
    begin
        pending_valid_next = pending_valid_reg;
        pending_tag_next   = pending_tag_reg;
        awaiting_next      = awaiting_reg;
        send_count_next    = send_count_reg;
        since_rx_next      = since_rx_reg;
        since_tx_next      = since_tx_reg;
        ack_push           = 1'b0;
        ack_pop            = 1'b0;
        late_push          = 1'b0;
        late_pop           = 1'b0;
        bundle             = '0;
        n_res              = 2'd0;

        case (command)
            hdx_pkg::CMD_TICK:
            begin
                since_rx_next = rx_inc;
                since_tx_next = tx_inc;
                awaiting_next = wait_on;
                if (!blocked)
                begin
                    if (pending_valid_reg && !give_up)
                    begin
                        // Resend the command still waiting for its ack.
                        bundle.r[n_res] = '{ev: hdx_pkg::EV_TRANSMIT,
                                            tag: pending_tag_reg, retry: 1'b1};
                        n_res         = n_res + 2'd1;
                        awaiting_next = 1'b1;
                        if (send_count_reg != '1)
                        begin
                            send_count_next = send_count_reg + 1'b1;
                        end
                        since_tx_next = '0;
                    end
                    else
                    begin
                        if (pending_valid_reg)
                        begin
                            bundle.r[n_res] = '{ev: hdx_pkg::EV_ACK_FAIL,
                                                tag: pending_tag_reg, retry: 1'b0};
                            n_res              = n_res + 2'd1;
                            pending_valid_next = 1'b0;
                            pending_tag_next   = '0;
                            awaiting_next      = 1'b0;
                            send_count_next    = '0;
                        end
                        if (!ack_empty)
                        begin
                            ack_pop         = 1'b1;
                            bundle.r[n_res] = '{ev: hdx_pkg::EV_TRANSMIT,
                                                tag: ack_head, retry: 1'b0};
                            n_res              = n_res + 2'd1;
                            pending_valid_next = 1'b1;
                            pending_tag_next   = ack_head;
                            awaiting_next      = 1'b1;
                            send_count_next    = hdx_pkg::RETRY_W'(1);
                            since_tx_next      = '0;
                        end
                        else if (!late_empty)
                        begin
                            // A command with no ack is done as soon as it goes out.
                            late_pop        = 1'b1;
                            bundle.r[n_res] = '{ev: hdx_pkg::EV_TRANSMIT,
                                                tag: late_head, retry: 1'b0};
                            n_res           = n_res + 2'd1;
                            bundle.r[n_res] = '{ev: hdx_pkg::EV_ACK_OK,
                                                tag: late_head, retry: 1'b0};
                            n_res           = n_res + 2'd1;
                            since_tx_next   = '0;
                        end
                    end
                end
            end
            hdx_pkg::CMD_ENQ:
            begin
                if ((needs_ack && ack_full) || (!needs_ack && late_full))
                begin
                    bundle.r[n_res] = '{ev: hdx_pkg::EV_DROPPED, tag: cmd_tag, retry: 1'b0};
                    n_res           = n_res + 2'd1;
                end
                else
                begin
                    ack_push  = needs_ack;
                    late_push = !needs_ack;
                end
            end
            hdx_pkg::CMD_FRAME:
            begin
                if (frame_ok)
                begin
                    since_rx_next = '0;
                    if (awaiting_reg && pending_valid_reg && ack_match)
                    begin
                        bundle.r[n_res] = '{ev: hdx_pkg::EV_ACK_OK,
                                            tag: pending_tag_reg, retry: 1'b0};
                        n_res              = n_res + 2'd1;
                        pending_valid_next = 1'b0;
                        pending_tag_next   = '0;
                        awaiting_next      = 1'b0;
                        send_count_next    = '0;
                    end
                    else
                    begin
                        bundle.r[n_res] = '{ev: hdx_pkg::EV_PUBLISHED, tag: '0, retry: 1'b0};
                        n_res           = n_res + 2'd1;
                    end
                end
            end
            default:
            begin
                n_res = 2'd0;
            end
        endcase

        // An item with no event still yields one quiet result.
        bundle.cnt = (n_res == 2'd0) ? 2'd1 : n_res;

        if (!accept)
        begin
            ack_push  = 1'b0;
            ack_pop   = 1'b0;
            late_push = 1'b0;
            late_pop  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_valid_reg <= 1'b0;
            pending_tag_reg   <= '0;
            awaiting_reg      <= 1'b0;
            send_count_reg    <= '0;
            since_rx_reg      <= '0;
            since_tx_reg      <= '0;
        end
        else if (accept)
        begin
            pending_valid_reg <= pending_valid_next;
            pending_tag_reg   <= pending_tag_next;
            awaiting_reg      <= awaiting_next;
            send_count_reg    <= send_count_next;
            since_rx_reg      <= since_rx_next;
            since_tx_reg      <= since_tx_next;
        end
    end

endmodule : hdx_front

`default_nettype wire

[rtl/core/hdx_back.sv]
// Back end: bundle queue and the sequencer that hands out one result beat at a time.
`default_nettype none

module hdx_back (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     bundle_push,
    input  wire hdx_pkg::bundle_t         bundle,
    output logic                          full,
    output logic                          empty,
    input  wire logic                     pop,
    output logic      [hdx_pkg::EV_W-1:0]  event_res,
    output logic      [hdx_pkg::TAG_W-1:0] event_tag,
    output logic                          is_retry,
    output logic                          last
);

    localparam int PW = (hdx_pkg::BQ_DEPTH > 1) ? $clog2(hdx_pkg::BQ_DEPTH) : 1;
    localparam int CW = $clog2(hdx_pkg::BQ_DEPTH + 1);

    hdx_pkg::bundle_t q_mem [hdx_pkg::BQ_DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic [1:0]       idx_reg;
    hdx_pkg::bundle_t cur;
    hdx_pkg::res_t    cur_res;
    logic             beat_done;
    logic             bundle_done;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(hdx_pkg::BQ_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign empty       = (count_reg == '0);
    assign full        = (count_reg == CW'(hdx_pkg::BQ_DEPTH));
    assign cur         = q_mem[rd_ptr_reg];
    assign cur_res     = cur.r[idx_reg];
    assign last        = (idx_reg == (cur.cnt - 2'd1));
    assign event_res   = cur_res.ev;
    assign event_tag   = cur_res.tag;
    assign is_retry    = cur_res.retry;
    assign beat_done   = pop && !empty;
    assign bundle_done = beat_done && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            if (bundle_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (bundle_done)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
                idx_reg    <= '0;
            end
            else if (beat_done)
            begin
                idx_reg <= idx_reg + 2'd1;
            end
            if (bundle_push && !bundle_done)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (!bundle_push && bundle_done)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (bundle_push)
        begin
            q_mem[wr_ptr_reg] <= bundle;
        end
    end

endmodule : hdx_back

`default_nettype wire

[rtl/core/half_duplex_tx_ack_retry_scheduler_unit.sv]
// Top level of the half-duplex transmit scheduler with ack wait and retries.
`default_nettype none

// Channel  | Direction | Handshake                      | Payload
// ---------+-----------+--------------------------------+------------------------------------
// input    | in        | push / full                    | command, cmd_tag, needs_ack,
//          |           |                                | frame_ok, ack_match
// result   | out       | empty / pop                    | event_res, event_tag, is_retry, last
// config   | in/out    | psel, penable, pwrite / pready | paddr, pwdata, prdata
//
// The front end takes one input beat per cycle while the two-entry bundle queue has room,
// so full is just the queue being full. Each item turns into one to three result beats.
// The back end hands out one result beat per cycle while pop is high, so sustained item
// throughput is set by the result count of each item and by the pop rate.
// An accepted item's first result is visible once the bundles ahead of it are handed out.
// Reset clears the FIFO counts, the scheduler state, both timers and the config registers.
// A stall on the result side fills the bundle queue and then raises full; nothing is lost.

module half_duplex_tx_ack_retry_scheduler_unit #(
    parameter int QUEUE_DEPTH = hdx_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,

    // Configuration port.
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [hdx_pkg::ADDR_W-1:0] paddr,
    input  wire logic [hdx_pkg::DATA_W-1:0] pwdata,
    output logic      [hdx_pkg::DATA_W-1:0] prdata,
    output logic                            pready,

    // Input items.
    input  wire logic                       push,
    output logic                            full,
    input  wire logic [hdx_pkg::CMD_W-1:0]  command,
    input  wire logic [hdx_pkg::TAG_W-1:0]  cmd_tag,
    input  wire logic                       needs_ack,
    input  wire logic                       frame_ok,
    input  wire logic                       ack_match,

    // Results.
    output logic                            empty,
    input  wire logic                       pop,
    output logic      [hdx_pkg::EV_W-1:0]   event_res,
    output logic      [hdx_pkg::TAG_W-1:0]  event_tag,
    output logic                            is_retry,
    output logic                            last
);

    hdx_pkg::cfg_t    cfg_reg;
    hdx_pkg::bundle_t bundle;
    logic             accept;
    logic             cfg_write;
    logic [1:0]       reg_idx;

    // Registers sit on word addresses; the word index picks the register.
    assign reg_idx   = paddr[3:2];
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                hdx_pkg::REG_GAP:     cfg_reg.gap_ms         <= pwdata[hdx_pkg::TIME_W-1:0];
                hdx_pkg::REG_TIMEOUT: cfg_reg.ack_timeout_ms <= pwdata[hdx_pkg::TIME_W-1:0];
                hdx_pkg::REG_RETRY:   cfg_reg.retry_limit    <= pwdata[hdx_pkg::RETRY_W-1:0];
                default:              cfg_reg                <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            hdx_pkg::REG_GAP:     prdata = hdx_pkg::DATA_W'(cfg_reg.gap_ms);
            hdx_pkg::REG_TIMEOUT: prdata = hdx_pkg::DATA_W'(cfg_reg.ack_timeout_ms);
            hdx_pkg::REG_RETRY:   prdata = hdx_pkg::DATA_W'(cfg_reg.retry_limit);
            default:              prdata = '0;
        endcase
    end

    // An input beat is taken whenever the bundle queue can hold its results.
    assign accept = push && !full;

    hdx_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .command   (command),
        .cmd_tag   (cmd_tag),
        .needs_ack (needs_ack),
        .frame_ok  (frame_ok),
        .ack_match (ack_match),
        .cfg       (cfg_reg),
        .bundle    (bundle)
    );

    hdx_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .bundle_push (accept),
        .bundle      (bundle),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .event_res   (event_res),
        .event_tag   (event_tag),
        .is_retry    (is_retry),
        .last        (last)
    );

endmodule : half_duplex_tx_ack_retry_scheduler_unit

`default_nettype wire

[tb/sv/tb_half_duplex_tx_ack_retry_scheduler_unit.sv]
// Self-checking testbench for the half-duplex transmit scheduler: directed plan, then random phases.
module tb_half_duplex_tx_ack_retry_scheduler_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import hdx_pkg::*;

    localparam int DEPTH         = QUEUE_DEPTH_DEF;
    localparam int QUIET_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int SHOWN_ERRORS  = 10;
    localparam int PHASE_ITEMS   = 48;
    localparam int MAX_CFG_TICKS = 8;

    // The block has no name for command code 3; it must be treated as a quiet item.
    localparam logic [CMD_W-1:0]   CMD_UNUSED = 2'd3;
    localparam logic [TIME_W-1:0]  TIME_SAT   = 16'hFFFF;
    localparam logic [RETRY_W-1:0] SEND_SAT   = 4'hF;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [TAG_W-1:0] tag;
        logic             needs_ack;
        logic             frame_ok;
        logic             ack_match;
    } item_t;

    typedef struct packed {
        logic [EV_W-1:0]  ev;
        logic [TAG_W-1:0] tag;
        logic             retry;
        logic             last;
    } beat_t;

    // One line of the directed plan; typed rows carry their single result beat.
    typedef struct packed {
        item_t      it;
        logic [7:0] reps;
        logic       typed;
        beat_t      want;
    } plan_row_t;

    logic               clk     = 1'b0;
    logic               rst_n   = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [ADDR_W-1:0]  paddr   = '0;
    logic [DATA_W-1:0]  pwdata  = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               push      = 1'b0;
    logic               full;
    logic [CMD_W-1:0]   command   = CMD_TICK;
    logic [TAG_W-1:0]   cmd_tag   = '0;
    logic               needs_ack = 1'b0;
    logic               frame_ok  = 1'b0;
    logic               ack_match = 1'b0;
    logic               empty;
    logic               pop       = 1'b0;
    logic [EV_W-1:0]    event_res;
    logic [TAG_W-1:0]   event_tag;
    logic               is_retry;
    logic               last;

    // Scheduler state as the testbench tracks it, starting from the reset values.
    logic [TIME_W-1:0]  cfg_gap     = '0;
    logic [TIME_W-1:0]  cfg_timeout = '0;
    logic [RETRY_W-1:0] cfg_retry   = '0;
    logic [TAG_W-1:0]   ack_line[$];
    logic [TAG_W-1:0]   late_line[$];
    logic               pend_valid  = 1'b0;
    logic [TAG_W-1:0]   pend_tag    = '0;
    logic               await_ack   = 1'b0;
    logic [RETRY_W-1:0] sends       = '0;
    logic [TIME_W-1:0]  since_rx    = '0;
    logic [TIME_W-1:0]  since_tx    = '0;

    beat_t              step_events[$];
    beat_t              due_events[$];
    plan_row_t          plan[$];
    int                 bad_events   = 0;
    int                 quiet_cycles = 0;
    int                 stall_left   = 0;
    bit                 rx_bursty    = 1'b0;
    bit                 tx_bursty    = 1'b0;

    half_duplex_tx_ack_retry_scheduler_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .push      (push),
        .full      (full),
        .command   (command),
        .cmd_tag   (cmd_tag),
        .needs_ack (needs_ack),
        .frame_ok  (frame_ok),
        .ack_match (ack_match),
        .empty     (empty),
        .pop       (pop),
        .event_res (event_res),
        .event_tag (event_tag),
        .is_retry  (is_retry),
        .last      (last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Idle stretch length: mostly none, often short, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void note(input logic [EV_W-1:0] ev, input logic [TAG_W-1:0] tag,
                                 input logic retry);
        beat_t b;
        b           = '{ev, tag, retry, 1'b0};
        step_events = {step_events, b};
    endfunction

    function automatic void drop_pending();
        pend_valid = 1'b0;
        pend_tag   = '0;
        await_ack  = 1'b0;
        sends      = '0;
    endfunction

    // Works out the result beats of one accepted item and advances the tracked state.
    function automatic void predict_schedule(input item_t it);
        logic             to_queues;
        logic [TAG_W-1:0] head_tag;
        step_events.delete();
        case (it.cmd)
            CMD_TICK:
            begin
                if (since_rx != TIME_SAT)
                    since_rx = since_rx + 1'b1;
                if (since_tx != TIME_SAT)
                    since_tx = since_tx + 1'b1;
                if (await_ack && since_tx > cfg_timeout)
                    await_ack = 1'b0;
                if (since_rx >= cfg_gap && since_tx >= cfg_gap && !await_ack)
                begin
                    to_queues = 1'b1;
                    if (pend_valid)
                    begin
                        if (cfg_retry <= sends)
                        begin
                            // Out of sends: report the failure and fall through to the queues.
                            note(EV_ACK_FAIL, pend_tag, 1'b0);
                            drop_pending();
                        end
                        else
                        begin
                            note(EV_TRANSMIT, pend_tag, 1'b1);
                            await_ack = 1'b1;
                            if (sends != SEND_SAT)
                                sends = sends + 1'b1;
                            since_tx  = '0;
                            to_queues = 1'b0;
                        end
                    end
                    if (to_queues && ack_line.size() != 0)
                    begin
                        pend_tag   = ack_line.pop_front();
                        note(EV_TRANSMIT, pend_tag, 1'b0);
                        pend_valid = 1'b1;
                        await_ack  = 1'b1;
                        sends      = 4'd1;
                        since_tx   = '0;
                    end
                    else if (to_queues && late_line.size() != 0)
                    begin
                        // A command without an ack is done as soon as it goes out.
                        head_tag = late_line.pop_front();
                        note(EV_TRANSMIT, head_tag, 1'b0);
                        note(EV_ACK_OK, head_tag, 1'b0);
                        since_tx = '0;
                    end
                end
            end
            CMD_ENQ:
            begin
                if (it.needs_ack)
                begin
                    if (ack_line.size() < DEPTH)
                        ack_line = {ack_line, it.tag};
                    else
                        note(EV_DROPPED, it.tag, 1'b0);
                end
                else
                begin
                    if (late_line.size() < DEPTH)
                        late_line = {late_line, it.tag};
                    else
                        note(EV_DROPPED, it.tag, 1'b0);
                end
            end
            CMD_FRAME:
            begin
                if (it.frame_ok)
                begin
                    since_rx = '0;
                    if (await_ack && pend_valid && it.ack_match)
                    begin
                        note(EV_ACK_OK, pend_tag, 1'b0);
                        drop_pending();
                    end
                    else
                        note(EV_PUBLISHED, '0, 1'b0);
                end
            end
            default:
            begin
            end
        endcase
        if (step_events.size() == 0)
            note(EV_NONE, '0, 1'b0);
    endfunction

    function automatic item_t rand_item();
        item_t it;
        int    r;
        it.tag       = TAG_W'($urandom_range(0, 255));
        it.needs_ack = ($urandom_range(0, 99) < 60);
        it.frame_ok  = ($urandom_range(0, 99) < 85);
        // While an ack is awaited, most frames are that ack, so exchanges complete.
        it.ack_match = ($urandom_range(0, 99) < (await_ack ? 75 : 30));
        r = $urandom_range(0, 99);
        if (r < 45)
            it.cmd = CMD_TICK;
        else if (r < 72)
            it.cmd = CMD_ENQ;
        else if (r < 95)
            it.cmd = CMD_FRAME;
        else
            it.cmd = CMD_UNUSED;
        return it;
    endfunction

    function automatic void add_row(input logic [CMD_W-1:0] cmd, input logic [TAG_W-1:0] tag,
                                    input logic ack, input logic ok, input logic match,
                                    input int reps, input logic typed,
                                    input logic [EV_W-1:0] ev, input logic [TAG_W-1:0] etag);
        plan_row_t row;
        row.it    = '{cmd, tag, ack, ok, match};
        row.reps  = 8'(reps);
        row.typed = typed;
        row.want  = '{ev, etag, 1'b0, 1'b1};
        plan      = {plan, row};
    endfunction

    // Drives one item beat, holds it until accepted, then queues its expected result beats.
    task automatic deliver(input item_t it, input logic typed, input beat_t want);
        int    idle_cycles;
        beat_t b;
        idle_cycles = tx_bursty ? gap_len() : 0;
        if (idle_cycles != 0)
        begin
            push <= 1'b0;
            repeat (idle_cycles) @(posedge clk);
        end
        push      <= 1'b1;
        command   <= it.cmd;
        cmd_tag   <= it.tag;
        needs_ack <= it.needs_ack;
        frame_ok  <= it.frame_ok;
        ack_match <= it.ack_match;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_schedule(it);
        if (typed)
            due_events = {due_events, want};
        else
        begin
            foreach (step_events[k])
            begin
                b          = step_events[k];
                b.last     = (k == step_events.size() - 1);
                due_events = {due_events, b};
            end
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_GAP:     cfg_gap     = val[TIME_W-1:0];
            REG_TIMEOUT: cfg_timeout = val[TIME_W-1:0];
            REG_RETRY:   cfg_retry   = val[RETRY_W-1:0];
            default:
            begin
            end
        endcase
    endtask

    // Registers change only once the block has handed out every beat it owes.
    task automatic configure(input logic [TIME_W-1:0] gap, input logic [TIME_W-1:0] timeout,
                             input logic [RETRY_W-1:0] retries);
        push <= 1'b0;
        while (due_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_reg(REG_GAP, DATA_W'(gap));
        write_reg(REG_TIMEOUT, DATA_W'(timeout));
        write_reg(REG_RETRY, DATA_W'(retries));
        tx_bursty = ($urandom_range(0, 3) != 0);
    endtask

    // Result side: check each popped beat against the oldest expectation, then pace pop.
    always @(posedge clk)
    begin : result_check
        beat_t got;
        beat_t want;
        if (rst_n && pop && !empty)
        begin
            got = '{event_res, event_tag, is_retry, last};
            if (due_events.size() == 0)
            begin
                bad_events++;
                if (bad_events <= SHOWN_ERRORS)
                    $display("%0t: unexpected result beat ev %0d tag %h retry %b last %b",
                             $time, got.ev, got.tag, got.retry, got.last);
            end
            else
            begin
                want = due_events.pop_front();
                if (got !== want)
                begin
                    bad_events++;
                    if (bad_events <= SHOWN_ERRORS)
                        $display({"%0t: result beat mismatch: expected ev %0d tag %h retry %b ",
                                  "last %b, got ev %0d tag %h retry %b last %b"},
                                 $time, want.ev, want.tag, want.retry, want.last,
                                 got.ev, got.tag, got.retry, got.last);
                end
            end
        end
        if ($urandom_range(0, 199) == 0)
            rx_bursty = !rx_bursty;
        if (stall_left != 0)
        begin
            stall_left--;
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
            if (rx_bursty)
                stall_left = gap_len();
        end
    end

    // Watchdog: too long without any beat moving on either side ends the run.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        item_t              it;
        beat_t              no_beat;
        int                 counted;
        logic [TIME_W-1:0]  phase_gap[6]     = '{16'd0, 16'd1, 16'd0, 16'd2, 16'd0, 16'd3};
        logic [TIME_W-1:0]  phase_timeout[6] = '{16'd0, 16'd2, 16'd0, 16'd1, 16'd3, 16'd5};
        logic [RETRY_W-1:0] phase_retry[6]   = '{4'd0, 4'd3, 4'd15, 4'd1, 4'd2, 4'd4};

        no_beat = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: one ms gap, one ms ack wait, two sends per command.
        configure(16'd1, 16'd1, 4'd2);
        // Quiet beats: nothing queued, a frame that failed its checks, the unused command code.
        add_row(CMD_TICK,   8'h00, 1'b0, 1'b0, 1'b0, 1, 1'b1, EV_NONE, 8'h00);
        add_row(CMD_FRAME,  8'hFF, 1'b1, 1'b0, 1'b1, 1, 1'b1, EV_NONE, 8'h00);
        add_row(CMD_UNUSED, 8'hFF, 1'b1, 1'b1, 1'b1, 1, 1'b1, EV_NONE, 8'h00);
        // A good frame with no ack awaited is published.
        add_row(CMD_FRAME,  8'h00, 1'b0, 1'b1, 1'b1, 1, 1'b1, EV_PUBLISHED, 8'h00);
        add_row(CMD_ENQ,    8'h00, 1'b1, 1'b0, 1'b0, 1, 1'b1, EV_NONE, 8'h00);
        add_row(CMD_ENQ,    8'hFF, 1'b0, 1'b1, 1'b1, 1, 1'b1, EV_NONE, 8'h00);
        add_row(CMD_ENQ,    8'hA5, 1'b1, 1'b0, 1'b0, 1, 1'b1, EV_NONE, 8'h00);
        // First send, then a matching ack.
        add_row(CMD_TICK,   8'h00, 1'b0, 1'b0, 1'b0, 1, 1'b0, EV_NONE, 8'h00);
        add_row(CMD_FRAME,  8'h00, 1'b0, 1'b1, 1'b1, 1, 1'b0, EV_NONE, 8'h00);
        // Send, wait out the timeout, resend, a stray frame, then the retry limit is hit
        // and the waiting command without an ack goes out on the same tick.
        add_row(CMD_TICK,   8'h00, 1'b0, 1'b0, 1'b0, 3, 1'b0, EV_NONE, 8'h00);
        add_row(CMD_FRAME,  8'h00, 1'b0, 1'b1, 1'b0, 1, 1'b0, EV_NONE, 8'h00);
        add_row(CMD_TICK,   8'h00, 1'b0, 1'b0, 1'b0, 2, 1'b0, EV_NONE, 8'h00);
        // Both queues overfilled: the seventeenth command of each is dropped.
        add_row(CMD_ENQ,    8'h10, 1'b0, 1'b0, 1'b0, DEPTH + 1, 1'b0, EV_NONE, 8'h00);
        add_row(CMD_ENQ,    8'h40, 1'b1, 1'b0, 1'b0, DEPTH + 1, 1'b0, EV_NONE, 8'h00);
        add_row(CMD_TICK,   8'h00, 1'b0, 1'b0, 1'b0, 4, 1'b0, EV_NONE, 8'h00);
        foreach (plan[i])
        begin
            for (int k = 0; k < plan[i].reps; k++)
            begin
                it     = plan[i].it;
                it.tag = it.tag + TAG_W'(k);
                deliver(it, plan[i].typed, plan[i].want);
            end
        end

        // Largest settings: the full-range gap holds every send back on these ticks,
        // and the queued commands wait for the next phase.
        configure(TIME_SAT, TIME_SAT, SEND_SAT);
        tx_bursty = 1'b0;
        deliver('{CMD_ENQ, 8'h3C, 1'b1, 1'b0, 1'b0}, 1'b0, no_beat);
        deliver('{CMD_ENQ, 8'hC3, 1'b0, 1'b0, 1'b0}, 1'b0, no_beat);
        for (int n = 0; n < MAX_CFG_TICKS; n++)
        begin
            it     = rand_item();
            it.cmd = CMD_TICK;
            deliver(it, 1'b0, no_beat);
        end

        // Random phases, each with new settings once the block has handed out every beat it owes.
        for (int p = 0; p < 6; p++)
        begin
            configure(phase_gap[p], phase_timeout[p], phase_retry[p]);
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                it = rand_item();
                deliver(it, 1'b0, no_beat);
                if (it.cmd != CMD_UNUSED && !(it.cmd == CMD_FRAME && !it.frame_ok))
                    counted++;
                if ($urandom_range(0, 49) == 0)
                    tx_bursty = !tx_bursty;
            end
        end

        push <= 1'b0;
        while (due_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (bad_events == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
